### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define AES_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/aes_pkg.sv
package aes_pkg;

  localparam int MaxKeyWords = 60;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;

  localparam logic [1:0] KEY_LEN_192 = 2'd1;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;

  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LENGTH = 3'd0,
    CFG_KEY_WORD_0 = 3'd1,
    CFG_KEY_WORD_1 = 3'd2,
    CFG_KEY_WORD_2 = 3'd3,
    CFG_KEY_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_ROUND
  } aes_state_t;

  typedef enum logic [1:0] {
    RK_FIRST,
    RK_MID,
    RK_LAST
  } round_kind_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef struct packed {
    logic       last;
    logic [3:0] nr;
  } key_stat_t;

  typedef logic [0:255][7:0] sbox_tbl_t;

  localparam sbox_tbl_t SBOX = {
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_tbl_t build_inv_sbox();
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tbl_t INV_SBOX = build_inv_sbox();

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte n of the state sits at bits [127-8n -: 8]
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] mul_coef(input logic [1:0] idx, input logic [7:0] b,
                                          input logic inv);
    logic [7:0] x2, x4, x8, res;
    x2 = xt(b);
    x4 = xt(x2);
    x8 = xt(x4);
    if (!inv) begin
      case (idx)
        2'd0:    res = x2;
        2'd1:    res = x2 ^ b;
        default: res = b;
      endcase
    end else begin
      case (idx)
        2'd0:    res = x8 ^ x4 ^ x2;
        2'd1:    res = x8 ^ x2 ^ b;
        2'd2:    res = x8 ^ x4 ^ b;
        default: res = x8 ^ b;
      endcase
    end
    return res;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc ^= mul_coef(2'((k + 4 - r) & 3), s[127-8*(4*c+k) -: 8], inv);
        end
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

endpackage

### rtl/aes_round.sv
module aes_round (
  input  logic                  dec,
  input  aes_pkg::round_kind_t  kind,
  input  logic [127:0]          st,
  input  logic [127:0]          rk,
  output logic [127:0]          res
);
  import aes_pkg::*;

  logic [127:0] enc_core;
  logic [127:0] dec_core;

  always_comb begin
    enc_core = shift_rows(sub_bytes(st, 1'b0), 1'b0);
    dec_core = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ rk;
    unique case (kind)
      RK_FIRST: res = st ^ rk;
      RK_MID:   res = dec ? mix_columns(dec_core, 1'b1) : (mix_columns(enc_core, 1'b0) ^ rk);
      RK_LAST:  res = dec ? dec_core : (enc_core ^ rk);
      default:  res = st ^ rk;
    endcase
  end

endmodule

### rtl/aes_key_sched.sv
module aes_key_sched #(
  parameter  int MAX_KEY_WORDS = aes_pkg::MaxKeyWords,
  localparam int ROWS          = (MAX_KEY_WORDS + 3) / 4,
  localparam int RW            = $clog2(ROWS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           key_length,
  input  logic [3:0][63:0]     key_words,
  input  logic [RW-1:0]        rd_row,
  output logic [127:0]         rd_key,
  output aes_pkg::key_stat_t   stat
);
  import aes_pkg::*;

  localparam int IW = $clog2(MAX_KEY_WORDS);

  logic [3:0][31:0] rk_mem_r [ROWS];
  logic [127:0]     rd_key_r;
  logic [31:0]      win_r [8];
  logic             active_r;
  logic [IW-1:0]    idx_r;
  logic [2:0]       j_r;
  logic [7:0]       rcon_r;
  logic [3:0]       nk_r;

  logic [3:0]  nk_cfg;
  logic [6:0]  total;
  logic        last;
  logic        from_key;
  logic [63:0] kw;
  logic [31:0] w_nk;
  logic [31:0] t;
  logic [31:0] w_new;

  // key lengths whose schedule does not fit the store fall back to a shorter key
  always_comb begin
    if (key_length >= KEY_LEN_256 && MAX_KEY_WORDS >= 60) begin
      nk_cfg = 4'd8;
    end else if (key_length >= KEY_LEN_192 && MAX_KEY_WORDS >= 52) begin
      nk_cfg = 4'd6;
    end else begin
      nk_cfg = 4'd4;
    end
  end

  always_comb begin
    total    = 7'({nk_r, 2'b00}) + 7'd28;
    last     = active_r && (7'(idx_r) == total - 7'd1);
    from_key = 7'(idx_r) < 7'(nk_r);
    kw       = key_words[idx_r[2:1]];
    case (nk_r)
      4'd4:    w_nk = win_r[3];
      4'd6:    w_nk = win_r[5];
      default: w_nk = win_r[7];
    endcase
    if (j_r == 3'd0) begin
      t = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk_r == 4'd8 && j_r == 3'd4) begin
      t = sub_word(win_r[0]);
    end else begin
      t = win_r[0];
    end
    w_new = from_key ? (idx_r[0] ? kw[31:0] : kw[63:32]) : (w_nk ^ t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
    end else if (last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r  <= '0;
      j_r    <= 3'd0;
      rcon_r <= 8'h01;
      nk_r   <= nk_cfg;
    end else if (active_r) begin
      idx_r <= idx_r + IW'(1);
      j_r   <= (4'(j_r) == nk_r - 4'd1) ? 3'd0 : j_r + 3'd1;
      if (!from_key && j_r == 3'd0) begin
        rcon_r <= xt(rcon_r);
      end
      win_r[0] <= w_new;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      rk_mem_r[RW'(idx_r >> 2)][2'd3 - idx_r[1:0]] <= w_new;
    end
    rd_key_r <= rk_mem_r[rd_row];
  end

  assign rd_key    = rd_key_r;
  assign stat.last = last;
  assign stat.nr   = nk_cfg + 4'd6;

endmodule

### rtl/aes_block_cipher.sv
// Sequence: the key schedule fills the round key store, a read fetches the first round
// key, the rounds run, then the result strobe is raised.
// One block at a time; busy stays high until the strobe cycle.
// The schedule writes one word per cycle; the shared round unit does one round per cycle.
// Reset (rst_n low, synchronous) clears the sequencer, the strobe and the key registers.
`include "assert_macros.svh"

module aes_block_cipher #(
  parameter int MAX_KEY_WORDS = aes_pkg::MaxKeyWords
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  aes_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output aes_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aes_pkg::CfgDataW-1:0] cfg_wdata
);
  import aes_pkg::*;

  localparam int ROWS = (MAX_KEY_WORDS + 3) / 4;
  localparam int RW   = $clog2(ROWS);

  aes_state_t       state_r, state_nxt;
  logic [1:0]       key_length_r;
  logic [3:0][63:0] key_words_r;
  logic [127:0]     st_r;
  logic             dec_r;
  logic [3:0]       rnd_r, rnd_nxt;
  logic             out_valid_r;
  logic [127:0]     result_r;

  logic             accept;
  logic             key_start;
  key_stat_t        kstat;
  logic [127:0]     rk;
  logic [RW-1:0]    rd_row;
  logic [3:0]       rnd_step;
  round_kind_t      kind;
  logic [127:0]     round_res;
  logic             final_round;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 2'd0;
      key_words_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH: key_length_r   <= cfg_wdata[1:0];
        CFG_KEY_WORD_0: key_words_r[0] <= cfg_wdata;
        CFG_KEY_WORD_1: key_words_r[1] <= cfg_wdata;
        CFG_KEY_WORD_2: key_words_r[2] <= cfg_wdata;
        CFG_KEY_WORD_3: key_words_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aes_key_sched #(
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (key_start),
    .key_length (key_length_r),
    .key_words  (key_words_r),
    .rd_row     (rd_row),
    .rd_key     (rk),
    .stat       (kstat)
  );

  always_comb begin
    if (dec_r) begin
      kind        = (rnd_r == kstat.nr) ? RK_FIRST : ((rnd_r == 4'd0) ? RK_LAST : RK_MID);
      final_round = (rnd_r == 4'd0);
      rnd_step    = rnd_r - 4'd1;
    end else begin
      kind        = (rnd_r == 4'd0) ? RK_FIRST : ((rnd_r == kstat.nr) ? RK_LAST : RK_MID);
      final_round = (rnd_r == kstat.nr);
      rnd_step    = rnd_r + 4'd1;
    end
  end

  aes_round u_round (
    .dec  (dec_r),
    .kind (kind),
    .st   (st_r),
    .rk   (rk),
    .res  (round_res)
  );

  // the key read runs one round ahead of the round unit
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    key_start = 1'b0;
    rd_row    = RW'(rnd_r);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_start = 1'b1;
          state_nxt = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (kstat.last) begin
          rnd_nxt   = (dec_r == OP_DECRYPT) ? kstat.nr : 4'd0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rd_row  = RW'(rnd_step);
        rnd_nxt = rnd_step;
        if (final_round) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_ROUND) && final_round;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    if (accept) begin
      st_r  <= {in_data.block_hi, in_data.block_lo};
      dec_r <= in_data.opcode;
    end else if (state_r == ST_ROUND) begin
      st_r <= round_res;
    end
    if (state_r == ST_ROUND && final_round) begin
      result_r <= round_res;
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_data.result_hi = result_r[127:64];
  assign out_data.result_lo = result_r[63:0];

  `AES_ASSERT_NEXT(a_accept_expands, clk, rst_n, accept, state_r == ST_EXPAND)
  `AES_ASSERT_NEXT(a_done_strobes, clk, rst_n, (state_r == ST_ROUND) && final_round, out_valid)
  `AES_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `AES_ASSERT_NEXT(a_sched_to_prep, clk, rst_n, (state_r == ST_EXPAND) && kstat.last, state_r == ST_PREP)

endmodule
